// ===== hw/rtl/tilt_frame_bcd_decoder_defines.svh =====
// Assertion macros for the tilt frame decoder checker.
`ifndef TILT_FRAME_BCD_DECODER_DEFINES_SVH
`define TILT_FRAME_BCD_DECODER_DEFINES_SVH

// ante must hold, then cons in the next clock
`define TFBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// ante and cons in the same clock
`define TFBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tfbd_pkg.sv =====
// Types, constants and the BCD conversion for the tilt frame decoder.
package tfbd_pkg;

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_FIELDS  = 3;

  typedef logic [23:0]        bcd_field_t;
  typedef logic signed [18:0] milli_t;

  localparam int MILLI_MAX = 166665;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEVICE_ID = 2'd0,
    REG_LENGTH    = 2'd1,
    REG_ADDRESS   = 2'd2,
    REG_COMMAND   = 2'd3
  } reg_idx_t;

  // frame byte positions
  localparam logic [5:0] POS_DEVICE_ID = 6'd0;
  localparam logic [5:0] POS_LENGTH    = 6'd1;
  localparam logic [5:0] POS_ADDRESS   = 6'd2;
  localparam logic [5:0] POS_COMMAND   = 6'd3;
  localparam logic [5:0] POS_PAYLOAD   = 6'd4;

  localparam logic [5:0] LENGTH_RESET = 6'd13;

  // field start positions: x tilt, y tilt, temperature
  localparam logic [5:0] X_FIELD_OFFSET = 6'd4;
  localparam logic [5:0] Y_FIELD_OFFSET = 6'd7;
  localparam logic [5:0] T_FIELD_OFFSET = 6'd10;

  localparam logic [5:0] FLD_OFFSET [NUM_FIELDS] = '{X_FIELD_OFFSET, Y_FIELD_OFFSET,
                                                     T_FIELD_OFFSET};

  // byte slot within a field
  localparam logic [1:0] SLOT_HI  = 2'd0;
  localparam logic [1:0] SLOT_MID = 2'd1;
  localparam logic [1:0] SLOT_LO  = 2'd2;

  // sign nibble, then five digits; nibbles above nine weighted as digits
  function automatic milli_t bcd_to_milli(bcd_field_t f);
    logic [17:0] mag;
    mag = 18'(f[19:16]) * 18'd10000 + 18'(f[15:12]) * 18'd1000
        + 18'(f[11:8]) * 18'd100 + 18'(f[7:4]) * 18'd10 + 18'(f[3:0]);
    if (f[23:20] != 4'h0) begin
      return milli_t'(19'd0 - {1'b0, mag});
    end
    return milli_t'({1'b0, mag});
  endfunction

endpackage

// ===== hw/rtl/tilt_frame_bcd_decoder.sv =====
// Tilt frame decoder: header hunt, additive checksum, signed BCD field capture.
// Output: when the checksum byte of a frame leaves the byte register, the result register
// loads the readings and raises out_valid; the byte waits while the result register is full.
// Throughput: one byte per cycle; the byte register and the result register each hand
// on when the next one has room, so only out_ready stalls it, and only at a frame end.
// Reset (rst_n low at a clock edge): header hunt restarts, sum cleared, registers
// take their defaults, pipeline emptied. Captured fields are not cleared.
module tilt_frame_bcd_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output tfbd_pkg::milli_t               out_x_tilt,
  output tfbd_pkg::milli_t               out_y_tilt,
  output tfbd_pkg::milli_t               out_temperature,
  output logic                           out_checksum_good,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tfbd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tfbd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tfbd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tfbd_pkg::*;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [7:0] dev_id_r;
  logic [5:0] len_r;
  logic [7:0] addr_r;
  logic [6:0] cmd_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r <= '0;
      len_r    <= LENGTH_RESET;
      addr_r   <= '0;
      cmd_r    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEVICE_ID: dev_id_r <= pwdata[7:0];
        REG_LENGTH:    len_r    <= pwdata[5:0];
        REG_ADDRESS:   addr_r   <= pwdata[7:0];
        REG_COMMAND:   cmd_r    <= pwdata[6:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEVICE_ID: prdata = CFG_DATA_W'(dev_id_r);
      REG_LENGTH:    prdata = CFG_DATA_W'(len_r);
      REG_ADDRESS:   prdata = CFG_DATA_W'(addr_r);
      REG_COMMAND:   prdata = CFG_DATA_W'(cmd_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: byte register -> result register
  // ---------------------------------------------------------------------------
  logic       s0_vld_r;
  logic [7:0] s0_byte_r;
  logic       out_vld_r;
  logic       s0_go;      // byte register hands its item to the frame logic
  logic       out_rdy;
  logic       frame_end;  // current byte is the checksum byte

  assign out_rdy  = !out_vld_r || out_ready;
  assign s0_go    = s0_vld_r && (!frame_end || out_rdy);
  assign in_ready = !s0_vld_r || s0_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s0_byte_r <= in_rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame tracking
  // ---------------------------------------------------------------------------
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [5:0] last_pos;     // checksum position, never inside the header
  logic [7:0] hdr_expect;
  logic       in_body;

  assign last_pos = (len_r < POS_PAYLOAD) ? POS_PAYLOAD : len_r;

  always_comb begin
    case (pos_r)
      POS_DEVICE_ID: hdr_expect = dev_id_r;
      POS_LENGTH:    hdr_expect = {2'b00, len_r};
      POS_ADDRESS:   hdr_expect = addr_r;
      POS_COMMAND:   hdr_expect = {1'b1, cmd_r};   // acknowledge bit set
      default:       hdr_expect = '0;
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    frame_end = 1'b0;
    in_body   = 1'b0;
    if (pos_r < POS_PAYLOAD) begin
      if (s0_byte_r == hdr_expect) begin
        sum_nxt = (pos_r == POS_DEVICE_ID) ? 8'd0 : sum_r + s0_byte_r;
        pos_nxt = pos_r + 6'd1;
      end else begin
        // mismatch: a byte equal to the id restarts as header byte 0
        sum_nxt = '0;
        pos_nxt = (s0_byte_r == dev_id_r) ? POS_LENGTH : POS_DEVICE_ID;
      end
    end else if (pos_r < last_pos) begin
      in_body = 1'b1;
      sum_nxt = sum_r + s0_byte_r;
      pos_nxt = pos_r + 6'd1;
    end else begin
      frame_end = 1'b1;
      sum_nxt   = '0;
      pos_nxt   = POS_DEVICE_ID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_DEVICE_ID;
      sum_r <= '0;
    end else if (s0_go) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Field capture, one lane per field; overlapping fields each take the byte
  // ---------------------------------------------------------------------------
  bcd_field_t fld_r [NUM_FIELDS];
  logic       fld_hit [NUM_FIELDS];
  logic [1:0] fld_slot [NUM_FIELDS];

  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      logic [5:0] diff;
      diff        = pos_r - FLD_OFFSET[k];
      fld_slot[k] = diff[1:0];
      fld_hit[k]  = in_body && (pos_r >= FLD_OFFSET[k]) && (diff < 6'd3);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (s0_go && fld_hit[k]) begin
        case (fld_slot[k])
          SLOT_HI:  fld_r[k][23:16] <= s0_byte_r;
          SLOT_MID: fld_r[k][15:8]  <= s0_byte_r;
          SLOT_LO:  fld_r[k][7:0]   <= s0_byte_r;
          default:  ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: BCD to thousandths and checksum verdict at the frame end
  // ---------------------------------------------------------------------------
  milli_t x_r, y_r, t_r;
  logic   chk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= s0_go && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && frame_end) begin
      x_r   <= bcd_to_milli(fld_r[0]);
      y_r   <= bcd_to_milli(fld_r[1]);
      t_r   <= bcd_to_milli(fld_r[2]);
      chk_r <= (sum_r == s0_byte_r);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_x_tilt        = x_r;
  assign out_y_tilt        = y_r;
  assign out_temperature   = t_r;
  assign out_checksum_good = chk_r;

endmodule

// ===== hw/rtl/tfbd_checker.sv =====
// Port-level checks for the tilt frame decoder, bound to the top level.
`include "tilt_frame_bcd_decoder_defines.svh"

module tfbd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input tfbd_pkg::milli_t out_x_tilt,
  input tfbd_pkg::milli_t out_y_tilt,
  input tfbd_pkg::milli_t out_temperature,
  input logic             out_checksum_good
);
  import tfbd_pkg::*;

  localparam milli_t LIM_HI = milli_t'(MILLI_MAX);
  localparam milli_t LIM_LO = milli_t'(-MILLI_MAX);

  `TFBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `TFBD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x_tilt) && $stable(out_y_tilt) && $stable(out_temperature) && $stable(out_checksum_good), "stalled result item changed")
  `TFBD_ASSERT_NOW(a_range, out_valid, out_x_tilt <= LIM_HI && out_x_tilt >= LIM_LO && out_y_tilt <= LIM_HI && out_y_tilt >= LIM_LO && out_temperature <= LIM_HI && out_temperature >= LIM_LO, "decoded value beyond five BCD digits")
  `TFBD_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid, "result shown straight after reset")

endmodule

bind tilt_frame_bcd_decoder tfbd_checker u_tfbd_checker (.*);

// ===== dv/tfbd_frame_checker.sv =====
// Frame checker for the tilt frame decoder: rebuilds readings from accepted bytes and compares.
`timescale 1ns / 100ps
module tfbd_frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  tfbd_pkg::milli_t                out_x_tilt,
  input  tfbd_pkg::milli_t                out_y_tilt,
  input  tfbd_pkg::milli_t                out_temperature,
  input  logic                            out_checksum_good,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tfbd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tfbd_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              pending_count
);
  import tfbd_pkg::*;

  typedef struct packed {
    milli_t x_tilt;
    milli_t y_tilt;
    milli_t temperature;
    logic   checksum_good;
  } reading_t;

  reading_t   expected_readings [$];

  // shadow registers
  logic [7:0] dev_id;
  logic [5:0] frame_len;
  logic [7:0] dev_addr;
  logic [6:0] report_cmd;

  // frame tracking
  logic [5:0] frame_pos;
  logic [7:0] frame_sum;
  bcd_field_t fields [NUM_FIELDS];

  function automatic milli_t to_thousandths(input bcd_field_t f);
    int mag;
    mag = f[19:16] * 10000 + f[15:12] * 1000 + f[11:8] * 100 + f[7:4] * 10 + f[3:0];
    if (f[23:20] != 4'h0) begin
      mag = -mag;
    end
    return milli_t'(mag);
  endfunction

  task automatic take_byte(input logic [7:0] b);
    logic [5:0] stop_pos;
    logic [7:0] hdr;
    int         rel;
    reading_t   reading;
    // lengths below the payload start put the checksum straight after the header
    stop_pos = (frame_len < POS_PAYLOAD) ? POS_PAYLOAD : frame_len;
    if (frame_pos < POS_PAYLOAD) begin
      case (frame_pos)
        POS_DEVICE_ID: hdr = dev_id;
        POS_LENGTH:    hdr = {2'b00, frame_len};
        POS_ADDRESS:   hdr = dev_addr;
        default:       hdr = {1'b1, report_cmd};
      endcase
      if (b == hdr) begin
        frame_sum = (frame_pos == POS_DEVICE_ID) ? 8'h00 : frame_sum + b;
        frame_pos = frame_pos + 6'd1;
      end else begin
        // a stray device id restarts the hunt one byte in
        frame_sum = 8'h00;
        frame_pos = (b == dev_id) ? POS_LENGTH : POS_DEVICE_ID;
      end
    end else if (frame_pos < stop_pos) begin
      frame_sum = frame_sum + b;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        rel = int'(frame_pos) - int'(FLD_OFFSET[k]);
        if (rel >= 0 && rel < 3) begin
          fields[k][8*(2-rel) +: 8] = b;
        end
      end
      frame_pos = frame_pos + 6'd1;
    end else begin
      reading.x_tilt        = to_thousandths(fields[0]);
      reading.y_tilt        = to_thousandths(fields[1]);
      reading.temperature   = to_thousandths(fields[2]);
      reading.checksum_good = (frame_sum == b);
      expected_readings.push_back(reading);
      frame_pos = POS_DEVICE_ID;
      frame_sum = 8'h00;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    reading_t want;
    if (!rst_n) begin
      dev_id     = 8'h00;
      frame_len  = LENGTH_RESET;
      dev_addr   = 8'h00;
      report_cmd = 7'h00;
      frame_pos  = POS_DEVICE_ID;
      frame_sum  = 8'h00;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading with none expected: x %0d y %0d t %0d ok %0d",
                 out_x_tilt, out_y_tilt, out_temperature, out_checksum_good);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("x_tilt", want.x_tilt, out_x_tilt);
          check_field("y_tilt", want.y_tilt, out_y_tilt);
          check_field("temperature", want.temperature, out_temperature);
          check_field("checksum_good", want.checksum_good, out_checksum_good);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_DEVICE_ID: dev_id     = pwdata[7:0];
          REG_LENGTH:    frame_len  = pwdata[5:0];
          REG_ADDRESS:   dev_addr   = pwdata[7:0];
          REG_COMMAND:   report_cmd = pwdata[6:0];
          default:       ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_byte(in_rx_byte);
      end
    end
    pending_count = expected_readings.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the tilt frame decoder: byte and register stimulus, verdict.
`timescale 1ns / 100ps
module tb_top;
  import tfbd_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int BYTE_TARGET     = 1100;   // stop opening phases past this many items
  localparam int PHASE_BYTES     = 90;     // rough items per register setting
  localparam int DRAIN_CYCLES    = 8;      // ample for bytes still in the pipe to settle
  localparam int HOLD_OFF_AT     = 300;    // item count at which the receiver holds off
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int END_WAIT_LIMIT  = 5000;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int WHOLE_FRAME     = 64;     // no frame is longer: send it all

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = 8'h00;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  milli_t                out_x_tilt;
  milli_t                out_y_tilt;
  milli_t                out_temperature;
  logic                  out_checksum_good;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int                    mismatches;
  int                    pending_count;
  int                    cycle_count  = 0;
  int                    bytes_sent   = 0;
  bit                    quiet_sender = 1'b0;   // no gaps between items when set

  // header as currently programmed, used to build frames
  logic [7:0]            hdr_dev;
  logic [5:0]            hdr_len;
  logic [7:0]            hdr_addr;
  logic [6:0]            hdr_cmd;

  tilt_frame_bcd_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x_tilt        (out_x_tilt),
    .out_y_tilt        (out_y_tilt),
    .out_temperature   (out_temperature),
    .out_checksum_good (out_checksum_good),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  tfbd_frame_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x_tilt        (out_x_tilt),
    .out_y_tilt        (out_y_tilt),
    .out_temperature   (out_temperature),
    .out_checksum_good (out_checksum_good),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatches        (mismatches),
    .pending_count     (pending_count)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One item on the byte channel. Entered at a falling edge; returns at the falling
  // edge after acceptance with valid still high, so the caller must either offer the
  // next item or drop valid in the same time step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet_sender) begin
      gap = $urandom_range(0, 99);
      if (gap < 65) begin
        gap = 0;
      end else if (gap < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // setup cycle then access cycle; pready is tied high but still honoured
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'({idx, 2'b00});
    pwdata  = CFG_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Sender pauses until every expected reading is back, then lets any partial
  // frame bytes still in the pipe settle before the registers move.
  task automatic drain_results;
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_header(input logic [7:0] d, input logic [5:0] l,
                            input logic [7:0] a, input logic [6:0] c);
    drain_results();
    write_reg(REG_DEVICE_ID, d);
    write_reg(REG_LENGTH, {2'b00, l});
    write_reg(REG_ADDRESS, a);
    write_reg(REG_COMMAND, {1'b0, c});
    hdr_dev  = d;
    hdr_len  = l;
    hdr_addr = a;
    hdr_cmd  = c;
  endtask

  // Signed BCD field: sign nibble then five digits. Wild fields take any nibbles.
  function automatic bcd_field_t rand_field(input bit wild);
    bcd_field_t f;
    if (wild) begin
      return bcd_field_t'($urandom);
    end
    f[23:20] = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(1, 15));
    for (int i = 0; i < 5; i++) begin
      f[4*i +: 4] = 4'($urandom_range(0, 9));
    end
    return f;
  endfunction

  // Builds a frame for the current header and sends its first max_bytes items.
  // Payload bytes outside the three fields are random filler.
  task automatic send_frame(input bcd_field_t fx, input bcd_field_t fy, input bcd_field_t ft,
                            input bit bad_sum, input int max_bytes);
    logic [7:0] frame [$];
    logic [7:0] sum;
    logic [7:0] b;
    bcd_field_t flds [NUM_FIELDS];
    int         stop_pos;
    int         rel;
    flds     = '{fx, fy, ft};
    stop_pos = (hdr_len < POS_PAYLOAD) ? int'(POS_PAYLOAD) : int'(hdr_len);
    frame    = '{hdr_dev, {2'b00, hdr_len}, hdr_addr, {1'b1, hdr_cmd}};
    // the sum starts at the length byte
    sum      = frame[1] + frame[2] + frame[3];
    for (int p = POS_PAYLOAD; p < stop_pos; p++) begin
      b = 8'($urandom);
      for (int k = 0; k < NUM_FIELDS; k++) begin
        rel = p - int'(FLD_OFFSET[k]);
        if (rel >= 0 && rel < 3) begin
          b = flds[k][8*(2-rel) +: 8];
        end
      end
      frame.push_back(b);
      sum = sum + b;
    end
    frame.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    foreach (frame[i]) begin
      if (i < max_bytes) send_byte(frame[i]);
    end
  endtask

  // part of a header, then a byte that cannot follow it
  task automatic send_broken_header;
    logic [7:0] hdr [4];
    logic [7:0] bad;
    int         keep;
    hdr  = '{hdr_dev, {2'b00, hdr_len}, hdr_addr, {1'b1, hdr_cmd}};
    keep = $urandom_range(1, 3);
    for (int i = 0; i < keep; i++) begin
      send_byte(hdr[i]);
    end
    bad = 8'($urandom);
    if (bad == hdr[keep]) bad ^= 8'h01;
    send_byte(bad);
  endtask

  task automatic send_noise;
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
  endtask

  // Receiver: bursts of steady ready, short and long stalls, and one long hold-off
  // while the sender keeps offering, so the pipe fills and in_ready drops.
  initial begin : receiver
    bit held;
    int r;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && bytes_sent >= HOLD_OFF_AT) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        out_ready = 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else if (r < 88) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_ready = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int         phase;
    int         start;
    int         r;
    int         waited;
    logic [5:0] len;
    phase = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n    = 1'b1;
    hdr_dev  = 8'h00;
    hdr_len  = LENGTH_RESET;
    hdr_addr = 8'h00;
    hdr_cmd  = 7'h00;

    // --- directed ---
    // Reset header. First frame writes every field byte, so later short frames
    // never read an unwritten field. Largest digits, all-zero and all-ones fields.
    send_frame(24'h099999, 24'h000000, 24'hFFFFFF, 1'b0, WHOLE_FRAME);
    // device id doubled: the mismatch at the length slot restarts one byte in;
    // non-BCD nibbles and a bad checksum
    send_byte(hdr_dev);
    send_frame(rand_field(1'b1), rand_field(1'b1), rand_field(1'b1), 1'b1, WHOLE_FRAME);
    // length below the payload start: checksum follows the header, no field captured
    set_header(8'h00, 6'd2, 8'h00, 7'h00);
    send_frame(rand_field(1'b0), rand_field(1'b0), rand_field(1'b0), 1'b0, WHOLE_FRAME);
    // length lowered mid-frame: stop at position 10, then shrink the length to 6
    // so the next item is taken as the checksum; temperature keeps its old bytes
    set_header(8'hA5, 6'd20, 8'h3C, 7'h11);
    send_frame(24'hF12345, 24'h054321, 24'h000000, 1'b0, 10);
    set_header(8'hA5, 6'd6, 8'h3C, 7'h11);
    send_byte(8'($urandom));

    // --- random phases, one register setting each ---
    while (bytes_sent < BYTE_TARGET) begin
      case (phase)
        0: set_header(8'hFF, 6'd63, 8'hFF, 7'h7F);
        1: set_header(8'h00, 6'd0, 8'h00, 7'h00);
        default: begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            len = 6'($urandom_range(13, 24));
          end else if (r < 85) begin
            len = 6'($urandom_range(0, 12));
          end else begin
            len = 6'($urandom_range(25, 63));
          end
          set_header(8'($urandom), len, 8'($urandom), 7'($urandom));
        end
      endcase
      quiet_sender = (phase % 4 == 3);
      start = bytes_sent;
      // mostly well-formed frames, some noise and broken headers between them
      while (bytes_sent - start < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          send_frame(rand_field($urandom_range(0, 5) == 0), rand_field($urandom_range(0, 5) == 0),
                     rand_field($urandom_range(0, 5) == 0), $urandom_range(0, 7) == 0,
                     WHOLE_FRAME);
        end else if (r < 89) begin
          send_noise();
        end else begin
          send_broken_header();
        end
      end
      phase++;
    end

    // --- wind down ---
    in_valid = 1'b0;
    waited   = 0;
    while (pending_count != 0 && waited < END_WAIT_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      if (pending_count != 0) $error("%0d readings never arrived", pending_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== tilt_frame_bcd_decoder.f =====
+incdir+hw/rtl
hw/rtl/tfbd_pkg.sv
hw/rtl/tilt_frame_bcd_decoder.sv
hw/rtl/tfbd_checker.sv
dv/tfbd_frame_checker.sv
dv/tb_top.sv
